FILE: rtl/core/iplpm_pkg.sv
`timescale 1ns / 1ps
package iplpm_pkg;

   localparam int Capacity = 256;
   localparam int SlotBits = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int AddrBits = 32;
   localparam int LenBits = 6;
   localparam int StampBits = 32;
   localparam logic [LenBits-1:0] MinLen = LenBits'(8);
   localparam logic [LenBits-1:0] MaxLen = LenBits'(32);

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [2:0] ST_MATCHED = 3'd0;
   localparam logic [2:0] ST_DEFAULT = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_BADLEN = 3'd4;
   localparam logic [2:0] ST_DELETED = 3'd5;
   localparam logic [2:0] ST_NOTFOUND = 3'd6;

   // Classified command handed from the front end to the scan engine.
   typedef struct packed {
      logic [1:0] op;
      logic [AddrBits-1:0] address;
      logic [LenBits-1:0] prefix_length;
   } cmd_type;

   // Finished result from the scan engine.
   typedef struct packed {
      logic [AddrBits-1:0] match_address;
      logic [LenBits-1:0] match_length;
      logic [2:0] status;
   } rsp_type;

   // Upper-bits mask for a prefix length.
   function automatic logic [AddrBits-1:0] prefix_mask(input logic [LenBits-1:0] len);
      logic [AddrBits-1:0] m;
      if (len >= LenBits'(AddrBits)) begin
         m = '1;
      end else begin
         m = ~({AddrBits{1'b1}} >> len);
      end
      return m;
   endfunction

endpackage

FILE: rtl/core/iplpm_front.sv
`timescale 1ns / 1ps
module iplpm_front import iplpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_op,
   input  logic [AddrBits-1:0] req_address,
   input  logic [LenBits-1:0] req_prefix_length,
   output logic cmd_valid,
   input  logic cmd_take,
   output cmd_type cmd
);

   // Two-entry command queue; unused op codes are folded into search here.
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic push_ok;
   cmd_type c_in;

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      c_in.op = (req_op == OP_INSERT || req_op == OP_DELETE) ? req_op : OP_SEARCH;
      c_in.address = req_address;
      c_in.prefix_length = req_prefix_length;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_ok) wr_ff <= !wr_ff;
         if (cmd_take) rd_ff <= !rd_ff;
      end
      if (push_ok) q_ff[wr_ff] <= c_in;
   end

endmodule

FILE: rtl/core/iplpm_engine.sv
`timescale 1ns / 1ps
module iplpm_engine import iplpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_take,
   input  cmd_type cmd,
   output logic res_valid,
   input  logic res_take,
   output rsp_type res
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;
   localparam logic [1:0] S_OUT = 2'd3;

   // Slot storage: valid bits in flops, payload in memory.
   logic [Capacity-1:0] valid_ff;
   logic [AddrBits-1:0] mem_addr [Capacity];
   logic [LenBits-1:0] mem_len [Capacity];
   logic [StampBits-1:0] mem_stamp [Capacity];
   logic [AddrBits-1:0] rd_addr_ff;
   logic [LenBits-1:0] rd_len_ff;
   logic [StampBits-1:0] rd_stamp_ff;

   logic [1:0] state_ff;
   cmd_type cmd_ff;
   logic [SlotBits:0] idx_ff;
   logic [SlotBits-1:0] rd_idx_ff;
   logic rd_live_ff;
   logic [StampBits-1:0] seq_ff;
   logic found_ff, free_found_ff;
   logic [SlotBits-1:0] best_ff, free_ff;
   logic [LenBits-1:0] best_len_ff;
   logic [StampBits-1:0] best_age_ff;
   logic [AddrBits-1:0] best_addr_ff;
   rsp_type res_ff;

   logic hit, better, len_ok;
   logic [StampBits-1:0] age;
   logic [AddrBits-1:0] mask;

   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;
   assign res_valid = (state_ff == S_OUT);
   assign res = res_ff;
   assign len_ok = (cmd_ff.prefix_length >= MinLen) && (cmd_ff.prefix_length <= MaxLen);

   // Compare the slot read in the previous cycle against the command.
   always_comb begin
      mask = prefix_mask(rd_len_ff);
      age = seq_ff - rd_stamp_ff;
      if (cmd_ff.op == OP_DELETE) begin
         hit = (rd_addr_ff == cmd_ff.address) && (rd_len_ff == cmd_ff.prefix_length);
         better = !found_ff || (age < best_age_ff);
      end else begin
         hit = ((rd_addr_ff & mask) == (cmd_ff.address & mask));
         better = !found_ff || (rd_len_ff > best_len_ff) ||
                  ((rd_len_ff == best_len_ff) && (age < best_age_ff));
      end
      hit = hit && rd_live_ff && valid_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= mem_addr[idx_ff[SlotBits-1:0]];
      rd_len_ff <= mem_len[idx_ff[SlotBits-1:0]];
      rd_stamp_ff <= mem_stamp[idx_ff[SlotBits-1:0]];
      if (state_ff == S_DONE && cmd_ff.op == OP_INSERT && len_ok && free_found_ff) begin
         mem_addr[free_ff] <= cmd_ff.address;
         mem_len[free_ff] <= cmd_ff.prefix_length;
         mem_stamp[free_ff] <= seq_ff;
      end
   end

   // Sequencer: one slot per cycle, then commit and present the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         seq_ff <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  idx_ff <= '0;
                  rd_live_ff <= 1'b0;
                  found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_idx_ff <= idx_ff[SlotBits-1:0];
               rd_live_ff <= (idx_ff < (SlotBits+1)'(Capacity));
               if (idx_ff < (SlotBits+1)'(Capacity)) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (!free_found_ff && !valid_ff[idx_ff[SlotBits-1:0]]) begin
                     free_found_ff <= 1'b1;
                     free_ff <= idx_ff[SlotBits-1:0];
                  end
               end else begin
                  state_ff <= S_DONE;
               end
               if (hit && better) begin
                  found_ff <= 1'b1;
                  best_ff <= rd_idx_ff;
                  best_len_ff <= rd_len_ff;
                  best_age_ff <= age;
                  best_addr_ff <= rd_addr_ff;
               end
            end
            S_DONE: begin
               res_ff.match_address <= '0;
               res_ff.match_length <= '0;
               case (cmd_ff.op)
                  OP_INSERT: begin
                     if (!len_ok) begin
                        res_ff.status <= ST_BADLEN;
                     end else if (free_found_ff) begin
                        valid_ff[free_ff] <= 1'b1;
                        seq_ff <= seq_ff + 1'b1;
                        res_ff.status <= ST_INSERTED;
                     end else begin
                        res_ff.status <= ST_FULL;
                     end
                  end
                  OP_DELETE: begin
                     if (found_ff) begin
                        valid_ff[best_ff] <= 1'b0;
                        res_ff.status <= ST_DELETED;
                     end else begin
                        res_ff.status <= ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (found_ff) begin
                        res_ff.match_address <= best_addr_ff;
                        res_ff.match_length <= best_len_ff;
                        res_ff.status <= ST_MATCHED;
                     end else begin
                        res_ff.status <= ST_DEFAULT;
                     end
                  end
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (res_take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/ipv4_longest_prefix_match_table.sv
`timescale 1ns / 1ps
// Channel   Ports                                        Transfer when
// request   req_op, req_address, req_prefix_length       req_push && !req_full
// response  rsp_match_address, rsp_match_length, rsp_status  rsp_pop && !rsp_empty
// Every operation scans all Capacity slots, one slot per cycle from the slot memory,
// and the scan engine takes no new item until its result has been popped.
// Reset clears all slot valid bits and the insert counter.
// A two-entry request queue keeps accepting, until full, while a result waits; the engine
// holds a finished result until it is popped.
module ipv4_longest_prefix_match_table import iplpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_op,
   input  logic [AddrBits-1:0] req_address,
   input  logic [LenBits-1:0] req_prefix_length,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [AddrBits-1:0] rsp_match_address,
   output logic [LenBits-1:0] rsp_match_length,
   output logic [2:0] rsp_status
);

   logic cmd_valid, cmd_take, res_valid;
   cmd_type cmd;
   rsp_type res;

   iplpm_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_op(req_op), .req_address(req_address),
      .req_prefix_length(req_prefix_length),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   iplpm_engine u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .res_valid(res_valid), .res_take(rsp_pop), .res(res)
   );

   // Result port view.
   assign rsp_empty = !res_valid;
   assign rsp_match_address = res.match_address;
   assign rsp_match_length = res.match_length;
   assign rsp_status = res.status;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import iplpm_pkg::*;

   localparam int CycleLimit = 2_000_000;
   localparam int DrainCycles = 600;
   localparam int RandomItems = 1130;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic [AddrBits-1:0] match_address;
      logic [LenBits-1:0] match_length;
      logic [2:0] status;
   } lookup_result_t;

   typedef struct {
      logic [1:0] op;
      logic [AddrBits-1:0] address;
      logic [LenBits-1:0] prefix_length;
      bit typed;
      lookup_result_t result;
   } script_row_t;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [1:0] req_op;
   logic [AddrBits-1:0] req_address;
   logic [LenBits-1:0] req_prefix_length;
   logic rsp_empty;
   logic rsp_pop;
   logic [AddrBits-1:0] rsp_match_address;
   logic [LenBits-1:0] rsp_match_length;
   logic [2:0] rsp_status;

   // Shadow copy of the prefix table.
   bit shadow_valid[Capacity];
   logic [AddrBits-1:0] shadow_address[Capacity];
   logic [LenBits-1:0] shadow_length[Capacity];
   logic [StampBits-1:0] shadow_stamp[Capacity];
   logic [StampBits-1:0] shadow_sequence;

   lookup_result_t pending_results[$];
   int error_count;
   int cycle_count;
   bit quiet;
   logic [AddrBits-1:0] base_pool[16];

   ipv4_longest_prefix_match_table u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_op(req_op),
      .req_address(req_address),
      .req_prefix_length(req_prefix_length),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_match_address(rsp_match_address),
      .rsp_match_length(rsp_match_length),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [AddrBits-1:0] len_mask(input logic [LenBits-1:0] len);
      if (len >= LenBits'(AddrBits)) return '1;
      return ~({AddrBits{1'b1}} >> len);
   endfunction

   // Applies one operation to the shadow table and returns its result.
   function automatic lookup_result_t lookup_update(input logic [1:0] op,
                                                   input logic [AddrBits-1:0] addr,
                                                   input logic [LenBits-1:0] len);
      lookup_result_t r;
      bit found;
      int best;
      logic [StampBits-1:0] age, best_age;
      logic [LenBits-1:0] best_len;
      r.match_address = '0;
      r.match_length = '0;
      found = 1'b0;
      best = 0;
      best_age = '0;
      best_len = '0;
      if (op == OP_INSERT) begin
         if (len < MinLen || len > MaxLen) begin
            r.status = ST_BADLEN;
         end else begin
            r.status = ST_FULL;
            for (int i = 0; i < Capacity; i++) begin
               if (!found && !shadow_valid[i]) begin
                  found = 1'b1;
                  shadow_valid[i] = 1'b1;
                  shadow_address[i] = addr;
                  shadow_length[i] = len;
                  shadow_stamp[i] = shadow_sequence;
                  shadow_sequence = shadow_sequence + 1;
                  r.status = ST_INSERTED;
               end
            end
         end
      end else if (op == OP_DELETE) begin
         for (int i = 0; i < Capacity; i++) begin
            if (shadow_valid[i] && shadow_address[i] == addr && shadow_length[i] == len) begin
               age = shadow_sequence - shadow_stamp[i];
               if (!found || age < best_age) begin
                  found = 1'b1;
                  best = i;
                  best_age = age;
               end
            end
         end
         if (found) shadow_valid[best] = 1'b0;
         r.status = found ? ST_DELETED : ST_NOTFOUND;
      end else begin
         // Search; the unused op code behaves the same way.
         for (int i = 0; i < Capacity; i++) begin
            if (shadow_valid[i] &&
                ((shadow_address[i] ^ addr) & len_mask(shadow_length[i])) == '0) begin
               age = shadow_sequence - shadow_stamp[i];
               if (!found || shadow_length[i] > best_len ||
                   (shadow_length[i] == best_len && age < best_age)) begin
                  found = 1'b1;
                  best_len = shadow_length[i];
                  best_age = age;
                  r.match_address = shadow_address[i];
               end
            end
         end
         r.match_length = found ? best_len : '0;
         if (!found) r.match_address = '0;
         r.status = found ? ST_MATCHED : ST_DEFAULT;
      end
      return r;
   endfunction

   // Presents one item and waits for its transfer, then records the expectation.
   task automatic send(input logic [1:0] op, input logic [AddrBits-1:0] addr,
                       input logic [LenBits-1:0] len, input bit typed,
                       input lookup_result_t typed_result);
      lookup_result_t r;
      int gap;
      if (!quiet && $urandom_range(99) < 27) begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_prefix_length <= len;
      @(posedge clock);
      while (req_full) @(posedge clock);
      r = lookup_update(op, addr, len);
      pending_results.push_back(typed ? typed_result : r);
   endtask

   function automatic int random_valid_slot();
      int start;
      start = $urandom_range(Capacity - 1);
      for (int k = 0; k < Capacity; k++) begin
         if (shadow_valid[(start + k) % Capacity]) return (start + k) % Capacity;
      end
      return -1;
   endfunction

   // Result side: random pop stalls and field checks.
   always @(posedge clock) begin
      lookup_result_t want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               report("unexpected result", rsp_status, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_match_address !== want.match_address)
                  report("match_address", rsp_match_address, want.match_address);
               if (rsp_match_length !== want.match_length)
                  report("match_length", rsp_match_length, want.match_length);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
            end
         end
      end
      rsp_pop <= quiet || ($urandom_range(99) >= 27);
   end

   initial begin
      script_row_t script[$];
      script_row_t row;
      lookup_result_t none;
      logic [1:0] op;
      logic [AddrBits-1:0] addr;
      logic [LenBits-1:0] len;
      int pick, slot;

      none = '{match_address: '0, match_length: '0, status: ST_DEFAULT};
      reset = 1'b1;
      req_push = 1'b0;
      req_op = OP_SEARCH;
      req_address = '0;
      req_prefix_length = '0;
      error_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      shadow_sequence = '0;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      foreach (base_pool[i]) base_pool[i] = $urandom;

      // Directed rows: typed results where they are obvious.
      script.push_back('{OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 1, none});
      script.push_back('{OP_SPARE, 32'h0000_0000, 6'd63, 1, none});
      script.push_back('{OP_DELETE, 32'h0A00_0000, 6'd8, 1, '{'0, '0, ST_NOTFOUND}});
      script.push_back('{OP_INSERT, 32'h0A00_0000, 6'd0, 1, '{'0, '0, ST_BADLEN}});
      script.push_back('{OP_INSERT, 32'h0A00_0000, 6'd7, 1, '{'0, '0, ST_BADLEN}});
      script.push_back('{OP_INSERT, 32'h0A00_0000, 6'd33, 1, '{'0, '0, ST_BADLEN}});
      script.push_back('{OP_INSERT, 32'hFFFF_FFFF, 6'd63, 1, '{'0, '0, ST_BADLEN}});
      script.push_back('{OP_INSERT, 32'h0A12_3456, 6'd8, 1, '{'0, '0, ST_INSERTED}});
      script.push_back('{OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1, '{'0, '0, ST_INSERTED}});
      script.push_back('{OP_INSERT, 32'h0000_0000, 6'd32, 1, '{'0, '0, ST_INSERTED}});
      script.push_back('{OP_SEARCH, 32'h0AFF_FFFF, 6'd0, 0, none});
      script.push_back('{OP_SEARCH, 32'hFFFF_FFFF, 6'd63, 0, none});
      script.push_back('{OP_SEARCH, 32'h0000_0000, 6'd0, 0, none});
      script.push_back('{OP_SEARCH, 32'h0B00_0000, 6'd0, 0, none});
      // Equal lengths: the newer of two entries wins.
      script.push_back('{OP_INSERT, 32'h0A01_0000, 6'd16, 0, none});
      script.push_back('{OP_INSERT, 32'h0A01_FFFF, 6'd16, 0, none});
      script.push_back('{OP_SEARCH, 32'h0A01_1234, 6'd0, 0, none});
      // Duplicates: one delete leaves the older copy.
      script.push_back('{OP_INSERT, 32'h0A01_0000, 6'd16, 0, none});
      script.push_back('{OP_DELETE, 32'h0A01_0000, 6'd16, 0, none});
      script.push_back('{OP_SEARCH, 32'h0A01_5678, 6'd0, 0, none});
      script.push_back('{OP_DELETE, 32'h0A01_FFFF, 6'd16, 0, none});
      script.push_back('{OP_SEARCH, 32'h0A01_5678, 6'd0, 0, none});
      script.push_back('{OP_SPARE, 32'h0A01_0001, 6'd40, 0, none});
      script.push_back('{OP_DELETE, 32'h0A01_0000, 6'd63, 1, '{'0, '0, ST_NOTFOUND}});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         row = script[i];
         send(row.op, row.address, row.prefix_length, row.typed, row.result);
      end

      // Random part: fill past capacity, then churn with deletes, inserts and searches.
      for (int n = 0; n < RandomItems; n++) begin
         quiet = (n >= 500 && n < 650);
         pick = $urandom_range(99);
         if (n < 320) op = (pick < 80) ? OP_INSERT : OP_SEARCH;
         else if (n < 520) op = (pick < 45) ? OP_DELETE : (pick < 55 ? OP_INSERT : OP_SEARCH);
         else op = (pick < 35) ? OP_SEARCH : (pick < 65 ? OP_INSERT : OP_DELETE);
         if ($urandom_range(99) < 3) op = OP_SPARE;
         len = $urandom_range(8, 32);
         addr = base_pool[$urandom_range(15)] ^ ($urandom >> $urandom_range(8, 31));
         if (op == OP_INSERT || op == OP_DELETE) begin
            if ($urandom_range(99) < 8) len = $urandom_range(63);
            if ($urandom_range(99) < 5) addr = $urandom;
            if (op == OP_DELETE && $urandom_range(99) < 75) begin
               slot = random_valid_slot();
               if (slot >= 0) begin
                  addr = shadow_address[slot];
                  len = shadow_length[slot];
               end
            end
         end else begin
            len = $urandom_range(63);
            slot = random_valid_slot();
            if (slot >= 0 && $urandom_range(99) < 70) begin
               addr = (shadow_address[slot] & len_mask(shadow_length[slot])) |
                      ($urandom & ~len_mask(shadow_length[slot]));
            end else if ($urandom_range(99) < 50) begin
               addr = $urandom;
            end
         end
         send(op, addr, len, 1'b0, none);
      end
      req_push <= 1'b0;
      quiet = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
